### src/small_blob_removal_filter_assert.svh
// Assertion macros used by the checker of the blob removal filter.
`ifndef SMALL_BLOB_REMOVAL_FILTER_ASSERT_SVH
`define SMALL_BLOB_REMOVAL_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbrf assertion failed");

// Next-cycle implication, disabled during reset.
`define SBRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbrf assertion failed");

`endif

### src/sbrf_pkg.sv
// ----------------------------------------------------------------------------
// sbrf_pkg
// Types and fixed constants of the small blob removal filter.
// ----------------------------------------------------------------------------
package sbrf_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mask_value;
    logic       last_pixel;
  } out_item_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIM_W      = 9;
  localparam int MING_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINGRP = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] FG_LEVEL = 8'hFF;
  localparam logic [7:0] MASK_ON  = 8'hFF;
  localparam logic [7:0] MASK_OFF = 8'h00;

  // pixel store entry: bit 1 visited, bit 0 foreground
  localparam logic [1:0] PIX_FG_NEW  = 2'b01;
  localparam logic [1:0] PIX_FG_SEEN = 2'b11;

endpackage

### src/small_blob_removal_filter.sv
// ----------------------------------------------------------------------------
// small_blob_removal_filter
// 8-connected area filter: keeps foreground regions larger than a threshold.
// ----------------------------------------------------------------------------
// Usage: send load transactions (operation 0) with one pixel each in raster
// order; only 255 is foreground. A load is taken every cycle while no flood
// pass runs, no size write or read is pending and out_stall does not hold a
// full output register. The load that completes width*height pixels starts
// the flood pass, during which in_stall stays high: a keep-map clear over the
// image, a read and a check state per raster position, up to 8 neighbour reads
// per foreground pixel (each a read and a check state of the pixel memory) and
// a mark step per pixel of each kept region. Read transactions (operation 1)
// return the mask in raster order, one result per read, with last_pixel on the
// final pixel; the readout then wraps. The next read waits for the keep memory
// read of the last. The result sits in an output register; a stall on out_
// holds it and stalls in_ while that register is full. Writing image_width or
// image_height restarts load and readout at pixel 0. Configuration is taken
// while no flood pass runs. After reset the mask reads as all zero, the size
// is 256 x 256 (clamped to the maximum) and the threshold is 0.
// ----------------------------------------------------------------------------
module small_blob_removal_filter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_REGION = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sbrf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sbrf_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbrf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sbrf_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int PIXN = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDXW = $clog2(PIXN);
  localparam int TW   = $clog2(PIXN + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RAW  = (MAX_REGION > 1) ? $clog2(MAX_REGION) : 1;
  localparam int RCW  = $clog2(MAX_REGION + 1);
  localparam int SW   = IDXW + XW + YW;
  localparam int EW_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int EH_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_POP_RD  = 4'd4;
  localparam logic [3:0] S_POP_GET = 4'd5;
  localparam logic [3:0] S_NB      = 4'd6;
  localparam logic [3:0] S_NB_CK   = 4'd7;
  localparam logic [3:0] S_MARK    = 4'd8;

  localparam logic [3:0] NB_DONE = 4'd8;

  // memories
  logic [1:0]      pix_mem [PIXN];
  logic            kp_mem  [PIXN];
  logic [SW-1:0]   stk_mem [PIXN];
  logic [IDXW-1:0] rl_mem  [MAX_REGION];

  logic            pix_we, kp_we, kp_wd, stk_we, rl_we;
  logic [IDXW-1:0] pix_wa, pix_ra, kp_wa, kp_ra, stk_wa, stk_ra, rl_wd;
  logic [RAW-1:0]  rl_wa, rl_ra;
  logic [1:0]      pix_wd, pix_q;
  logic [SW-1:0]   stk_wd, stk_q;
  logic [IDXW-1:0] rl_q;
  logic            kp_q;

  // configuration and control registers
  logic [WW-1:0]     ew_r, ew_nxt;
  logic [HW-1:0]     eh_r, eh_nxt;
  logic [MING_W-1:0] ming_r, ming_nxt;
  logic [TW-1:0]     total_r;
  logic              cfg_pend_r, cfg_pend_nxt;
  logic [TW-1:0]     vtot_r, vtot_nxt;
  logic [TW-1:0]     load_idx_r, load_idx_nxt;
  logic [TW-1:0]     read_idx_r, read_idx_nxt;
  logic [3:0]        state_r, state_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // flood datapath registers
  logic [TW-1:0]   start_r, start_nxt, clr_r, clr_nxt, top_r, top_nxt, cnt_r, cnt_nxt;
  logic [XW-1:0]   sx_r, sx_nxt, px_r, px_nxt, qx_r, qx_nxt;
  logic [YW-1:0]   sy_r, sy_nxt, py_r, py_nxt, qy_r, qy_nxt;
  logic [IDXW-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [3:0]      nb_r, nb_nxt;
  logic [RCW-1:0]  listed_r, listed_nxt, mi_r, mi_nxt;
  logic            mv_r, mv_nxt;
  logic            rd_zero_r, rd_zero_nxt, rd_last_r, rd_last_nxt;
  out_item_t       out_data_r;

  logic            in_acc, cfg_acc;
  logic [WW+HW-1:0] prod;
  logic [TW-1:0]   li, li1, ri, ri1;
  logic            dxm, dxp, dym, dyp, nb_ok;
  logic [IDXW:0]   qbase, qcalc;
  logic [XW-1:0]   nx;
  logic [YW-1:0]   ny;

  function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
    logic [WW-1:0] r;
    if (v == '0) r = WW'(1);
    else if (32'(v) > MAX_WIDTH) r = WW'(MAX_WIDTH);
    else r = WW'(v);
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [DIM_W-1:0] v);
    logic [HW-1:0] r;
    if (v == '0) r = HW'(1);
    else if (32'(v) > MAX_HEIGHT) r = HW'(MAX_HEIGHT);
    else r = HW'(v);
    return r;
  endfunction

  assign in_acc    = in_valid & ~in_stall;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != S_IDLE) | cfg_pend_r | rd_pend_r | (out_valid_r & out_stall);
  assign cfg_ready = (state_r == S_IDLE) & ~rd_pend_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // image size product, registered into total_r after a size write
  assign prod = {{HW{1'b0}}, ew_r} * {{WW{1'b0}}, eh_r};

  // wrapped load and read positions
  assign li  = (load_idx_r >= total_r) ? '0 : load_idx_r;
  assign li1 = li + TW'(1);
  assign ri  = (read_idx_r >= total_r) ? '0 : read_idx_r;
  assign ri1 = ri + TW'(1);

  // neighbour offsets in scan order: row above, same row, row below
  assign dym = (nb_r[2:0] < 3'd3);
  assign dyp = (nb_r[2:0] > 3'd4);
  assign dxm = (nb_r[2:0] == 3'd0) | (nb_r[2:0] == 3'd3) | (nb_r[2:0] == 3'd5);
  assign dxp = (nb_r[2:0] == 3'd2) | (nb_r[2:0] == 3'd4) | (nb_r[2:0] == 3'd7);
  assign nb_ok = ~(dxm & (px_r == '0)) &
                 ~(dxp & ((XW+1)'(px_r) + (XW+1)'(1) >= (XW+1)'(ew_r))) &
                 ~(dym & (py_r == '0)) &
                 ~(dyp & ((YW+1)'(py_r) + (YW+1)'(1) >= (YW+1)'(eh_r)));
  assign qbase = dym ? ({1'b0, p_r} - (IDXW+1)'(ew_r)) :
                 dyp ? ({1'b0, p_r} + (IDXW+1)'(ew_r)) : {1'b0, p_r};
  assign qcalc = dxm ? (qbase - (IDXW+1)'(1)) : dxp ? (qbase + (IDXW+1)'(1)) : qbase;
  assign nx    = dxm ? (px_r - XW'(1)) : dxp ? (px_r + XW'(1)) : px_r;
  assign ny    = dym ? (py_r - YW'(1)) : dyp ? (py_r + YW'(1)) : py_r;

  // control and flood sequencer
  always_comb begin
    ew_nxt = ew_r; eh_nxt = eh_r; ming_nxt = ming_r;
    cfg_pend_nxt = 1'b0;
    vtot_nxt = vtot_r; load_idx_nxt = load_idx_r; read_idx_nxt = read_idx_r;
    state_nxt = state_r; rd_pend_nxt = 1'b0;
    rd_zero_nxt = rd_zero_r; rd_last_nxt = rd_last_r;
    out_valid_nxt = out_valid_r;
    start_nxt = start_r; clr_nxt = clr_r; top_nxt = top_r; cnt_nxt = cnt_r;
    sx_nxt = sx_r; sy_nxt = sy_r; px_nxt = px_r; py_nxt = py_r; qx_nxt = qx_r; qy_nxt = qy_r;
    p_nxt = p_r; q_nxt = q_r; nb_nxt = nb_r; listed_nxt = listed_r; mi_nxt = mi_r;
    mv_nxt = 1'b0;
    pix_we = 1'b0; pix_wa = '0; pix_wd = '0; pix_ra = '0;
    kp_we = 1'b0; kp_wa = '0; kp_wd = 1'b0; kp_ra = IDXW'(ri);
    stk_we = 1'b0; stk_wa = IDXW'(top_r); stk_wd = '0; stk_ra = '0;
    rl_we = 1'b0; rl_wa = RAW'(listed_r); rl_wd = '0; rl_ra = RAW'(mi_r);

    // release the output register
    if (out_valid_r & ~out_stall) out_valid_nxt = 1'b0;
    if (rd_pend_r) out_valid_nxt = 1'b1;

    // configuration write
    if (cfg_acc) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          ew_nxt = clamp_w(cfg_wdata[DIM_W-1:0]);
          cfg_pend_nxt = 1'b1; load_idx_nxt = '0; read_idx_nxt = '0;
        end
        REG_HEIGHT: begin
          eh_nxt = clamp_h(cfg_wdata[DIM_W-1:0]);
          cfg_pend_nxt = 1'b1; load_idx_nxt = '0; read_idx_nxt = '0;
        end
        REG_MINGRP: ming_nxt = cfg_wdata[MING_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.operation == OP_LOAD) begin
          pix_we = 1'b1;
          pix_wa = IDXW'(li);
          pix_wd = (in_data.pixel_value == FG_LEVEL) ? PIX_FG_NEW : 2'b00;
          if (li1 >= total_r) begin
            load_idx_nxt = '0; read_idx_nxt = '0;
            clr_nxt = '0; state_nxt = S_CLR;
          end else begin
            load_idx_nxt = li1;
          end
        end else if (in_acc) begin
          rd_pend_nxt = 1'b1;
          rd_zero_nxt = (ri >= vtot_r);
          rd_last_nxt = (ri1 == total_r);
          read_idx_nxt = (ri1 >= total_r) ? '0 : ri1;
        end
      end
      S_CLR: begin
        // clear the keep map over the image
        kp_we = 1'b1; kp_wa = IDXW'(clr_r);
        clr_nxt = clr_r + TW'(1);
        if (clr_nxt == total_r) begin
          vtot_nxt = total_r;
          start_nxt = '0; sx_nxt = '0; sy_nxt = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        pix_ra = IDXW'(start_r);
        state_nxt = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (pix_q == PIX_FG_NEW) begin
          // seed a new region
          pix_we = 1'b1; pix_wa = IDXW'(start_r); pix_wd = PIX_FG_SEEN;
          stk_we = 1'b1; stk_wa = '0; stk_wd = {IDXW'(start_r), sx_r, sy_r};
          top_nxt = TW'(1); cnt_nxt = '0; listed_nxt = '0;
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_POP_RD: begin
        stk_ra = IDXW'(top_r - TW'(1));
        top_nxt = top_r - TW'(1);
        state_nxt = S_POP_GET;
      end
      S_POP_GET: begin
        {p_nxt, px_nxt, py_nxt} = stk_q;
        cnt_nxt = cnt_r + TW'(1);
        if (32'(listed_r) < MAX_REGION) begin
          rl_we = 1'b1; rl_wd = stk_q[SW-1 -: IDXW];
          listed_nxt = listed_r + RCW'(1);
        end
        nb_nxt = '0;
        state_nxt = S_NB;
      end
      S_NB: begin
        if (nb_r == NB_DONE) begin
          if (top_r != '0) begin
            state_nxt = S_POP_RD;
          end else if (32'(cnt_r) > 32'(ming_r) && listed_r != '0) begin
            mi_nxt = '0;
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else if (nb_ok) begin
          pix_ra = qcalc[IDXW-1:0];
          q_nxt = qcalc[IDXW-1:0]; qx_nxt = nx; qy_nxt = ny;
          state_nxt = S_NB_CK;
        end else begin
          nb_nxt = nb_r + 4'd1;
        end
      end
      S_NB_CK: begin
        if (pix_q == PIX_FG_NEW) begin
          pix_we = 1'b1; pix_wa = q_r; pix_wd = PIX_FG_SEEN;
          stk_we = 1'b1; stk_wd = {q_r, qx_r, qy_r};
          top_nxt = top_r + TW'(1);
        end
        nb_nxt = nb_r + 4'd1;
        state_nxt = S_NB;
      end
      S_MARK: begin
        // stream the region list into the keep map
        if (mi_r != listed_r) begin
          mi_nxt = mi_r + RCW'(1);
          mv_nxt = 1'b1;
        end
        if (mv_r) begin
          kp_we = 1'b1; kp_wa = rl_q; kp_wd = 1'b1;
        end
        if (mi_r == listed_r && !mv_r) state_nxt = S_SCAN_RD;
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance the raster scan after a position is finished
    if (state_nxt == S_SCAN_RD && state_r != S_CLR) begin
      if (start_r + TW'(1) == total_r) begin
        state_nxt = S_IDLE;
      end else begin
        start_nxt = start_r + TW'(1);
        if ((XW+1)'(sx_r) + (XW+1)'(1) == (XW+1)'(ew_r)) begin
          sx_nxt = '0; sy_nxt = sy_r + YW'(1);
        end else begin
          sx_nxt = sx_r + XW'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r <= WW'(EW_RST); eh_r <= HW'(EH_RST); ming_r <= '0;
      cfg_pend_r <= 1'b1; vtot_r <= '0;
      load_idx_r <= '0; read_idx_r <= '0;
      state_r <= S_IDLE; rd_pend_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      ew_r <= ew_nxt; eh_r <= eh_nxt; ming_r <= ming_nxt;
      cfg_pend_r <= cfg_pend_nxt; vtot_r <= vtot_nxt;
      load_idx_r <= load_idx_nxt; read_idx_r <= read_idx_nxt;
      state_r <= state_nxt; rd_pend_r <= rd_pend_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    total_r <= prod[TW-1:0];
    start_r <= start_nxt; clr_r <= clr_nxt; top_r <= top_nxt; cnt_r <= cnt_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; px_r <= px_nxt; py_r <= py_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; p_r <= p_nxt; q_r <= q_nxt; nb_r <= nb_nxt;
    listed_r <= listed_nxt; mi_r <= mi_nxt; mv_r <= mv_nxt;
    rd_zero_r <= rd_zero_nxt; rd_last_r <= rd_last_nxt;
    if (rd_pend_r) begin
      out_data_r.mask_value <= (rd_zero_r | ~kp_q) ? MASK_OFF : MASK_ON;
      out_data_r.last_pixel <= rd_last_r;
    end
  end

  // pixel store: foreground and visited bits
  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    pix_q <= pix_mem[pix_ra];
  end

  // keep map
  always_ff @(posedge clk) begin
    if (kp_we) kp_mem[kp_wa] <= kp_wd;
    kp_q <= kp_mem[kp_ra];
  end

  // flood stack of {index, x, y}
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

  // region list
  always_ff @(posedge clk) begin
    if (rl_we) rl_mem[rl_wa] <= rl_wd;
    rl_q <= rl_mem[rl_ra];
  end

endmodule

### src/sbrf_checker.sv
// ----------------------------------------------------------------------------
// sbrf_checker
// Port-level checks of the small blob removal filter, bound to the top level.
// ----------------------------------------------------------------------------
module sbrf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input sbrf_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input sbrf_pkg::out_item_t             out_data
);
  import sbrf_pkg::*;
`include "small_blob_removal_filter_assert.svh"

  logic mask_ok;

  assign mask_ok = (out_data.mask_value == MASK_ON) || (out_data.mask_value == MASK_OFF);

  // hold a stalled result
  `SBRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SBRF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // mask is binary
  `SBRF_ASSERT_NOW(a_mask_code, clk, rst_n, out_valid, mask_ok)
  // a load transaction produces no result
  `SBRF_ASSERT_NEXT(a_load_silent, clk, rst_n, !out_valid && in_valid && !in_stall && in_data.operation == OP_LOAD, !out_valid)

endmodule

bind small_blob_removal_filter sbrf_checker u_sbrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the small blob removal filter: directed table of
// loads and reads, then random images of many sizes checked by a predictor.
// ----------------------------------------------------------------------------
module testbench;
  import sbrf_pkg::*;

  localparam int PIX_MAX = 256 * 256;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1250;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  small_blob_removal_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [8:0] pr_width, pr_height;
  logic [16:0] pr_min_group;
  bit pr_fg [PIX_MAX];
  bit pr_seen [PIX_MAX];
  bit pr_keep [PIX_MAX];
  int pr_load_idx, pr_read_idx;

  out_item_t mask_q[$];
  int mismatches = 0;
  int unexpected = 0;
  int results_seen = 0;
  int items_sent = 0;
  int images_filtered = 0;
  bit hold_req = 0;

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // Label 8-connected foreground regions, keep the ones above threshold
  function automatic void run_flood();
    int w, h, total, p, x, y, q, count;
    int stack[$];
    int region[$];
    w = eff_dim(pr_width);
    h = eff_dim(pr_height);
    total = w * h;
    for (int i = 0; i < PIX_MAX; i++) pr_keep[i] = 0;
    for (int s = 0; s < total; s++) begin
      if (!pr_fg[s] || pr_seen[s]) continue;
      pr_seen[s] = 1;
      stack.delete();
      region.delete();
      stack.push_back(s);
      count = 0;
      while (stack.size() > 0) begin
        p = stack.pop_back();
        x = p % w;
        y = p / w;
        count++;
        region.push_back(p);
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0) continue;
            if (x + dx < 0 || x + dx >= w || y + dy < 0 || y + dy >= h) continue;
            q = (y + dy) * w + x + dx;
            if (pr_fg[q] && !pr_seen[q]) begin
              pr_seen[q] = 1;
              stack.push_back(q);
            end
          end
        end
      end
      if (count > pr_min_group) foreach (region[k]) pr_keep[region[k]] = 1;
    end
    images_filtered++;
  endfunction

  function automatic void predict_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WIDTH: begin
        pr_width = val[8:0];
        pr_load_idx = 0;
        pr_read_idx = 0;
      end
      REG_HEIGHT: begin
        pr_height = val[8:0];
        pr_load_idx = 0;
        pr_read_idx = 0;
      end
      REG_MINGRP: pr_min_group = val;
      default: ;
    endcase
  endfunction

  // Returns 1 and the mask pixel when the transaction is a read
  function automatic bit predict_step(in_item_t it, output out_item_t res);
    int total;
    total = eff_dim(pr_width) * eff_dim(pr_height);
    res = '0;
    if (it.operation == OP_LOAD) begin
      if (pr_load_idx >= total) pr_load_idx = 0;
      pr_fg[pr_load_idx] = (it.pixel_value == FG_LEVEL);
      pr_seen[pr_load_idx] = 0;
      pr_load_idx++;
      if (pr_load_idx >= total) begin
        run_flood();
        pr_load_idx = 0;
        pr_read_idx = 0;
      end
      return 0;
    end
    if (pr_read_idx >= total) pr_read_idx = 0;
    res.mask_value = pr_keep[pr_read_idx] ? MASK_ON : MASK_OFF;
    res.last_pixel = (pr_read_idx + 1 == total);
    pr_read_idx++;
    if (pr_read_idx >= total) pr_read_idx = 0;
    return 1;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    #100000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: random stall pattern, long hold-off on request
  int hold_cnt = 0;
  int stall_mode = 0;
  int mode_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_cnt == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_cnt <= $urandom_range(16, 96);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (mask_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: mask %0h last %0b", out_data.mask_value,
                   out_data.last_pixel);
      end else begin
        out_item_t want;
        want = mask_q.pop_front();
        if (want.mask_value !== out_data.mask_value ||
            want.last_pixel !== out_data.last_pixel) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch #%0d: expected mask %0h last %0b, got mask %0h last %0b",
                     results_seen, want.mask_value, want.last_pixel,
                     out_data.mask_value, out_data.last_pixel);
        end
      end
    end
  end

  // Sender burst control
  int burst_left = 0;
  bit gaps_on = 1;

  // Offer one transaction; push the expectation at acceptance
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t res;
    bit has_res;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    has_res = predict_step(it, res);
    if (has_res) mask_q.push_back(typed ? typed_exp : res);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic wait_idle();
    end_burst();
    @(posedge clk);
    while (mask_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    predict_cfg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(logic [16:0] w, logic [16:0] h, logic [16:0] m);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MINGRP, m);
  endtask

  typedef struct {
    bit do_cfg;
    logic [16:0] w, h, m;
    in_item_t it;
    bit typed;
    out_item_t exp;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(bit c, logic [16:0] w, logic [16:0] h, logic [16:0] m,
                              logic op, logic [7:0] px, bit t, logic [7:0] em, bit el);
    row_t r;
    r.do_cfg = c;
    r.w = w;
    r.h = h;
    r.m = m;
    r.it.operation = op;
    r.it.pixel_value = px;
    r.typed = t;
    r.exp.mask_value = em;
    r.exp.last_pixel = el;
    return r;
  endfunction

  initial begin
    int w, h, total, dens, n_reads;
    int phase;
    in_item_t it;
    out_item_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pr_width = 256;
    pr_height = 256;
    pr_min_group = 0;
    pr_load_idx = 0;
    pr_read_idx = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads before any filtering, small images, clamped sizes
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 0, 1, MASK_OFF, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 255, 1, MASK_OFF, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 128, 1, MASK_OFF, 0));
    rows.push_back(mk(1, 3, 2, 1, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 254, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 128, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 255, 0, 0, 0));
    for (int i = 0; i < 7; i++) rows.push_back(mk(0, 0, 0, 0, OP_READ, 85, 0, 0, 0));
    rows.push_back(mk(1, 0, 1, 0, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 0, 1, MASK_ON, 1));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 0, 1, MASK_ON, 1));
    rows.push_back(mk(1, 1, 0, 65536, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 0, 1, MASK_OFF, 1));
    rows.push_back(mk(1, 2, 2, 0, OP_LOAD, 0, 0, 0, 0));
    rows.push_back(mk(1, 2, 2, 0, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_LOAD, 255, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, OP_READ, 0, 0, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].do_cfg) begin
        wait_idle();
        set_size(rows[i].w, rows[i].h, rows[i].m);
      end
      send_item(rows[i].it, rows[i].typed, rows[i].typed ? rows[i].exp : none);
    end
    wait_idle();
    write_reg(REG_UNUSED, 17'($urandom()));

    // Random images; first phases take the size extremes
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      wait_idle();
      case (phase)
        0: begin w = 256; h = 1; end
        1: begin w = 1; h = 300; end
        2: begin w = 511; h = 0; end
        default: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(1, 16);
        end
      endcase
      write_reg(REG_WIDTH, 17'(($urandom() & 32'h1FE00) | w));
      write_reg(REG_HEIGHT, 17'(h));
      case ($urandom_range(0, 7))
        0: write_reg(REG_MINGRP, 17'h1FFFF);
        1: write_reg(REG_MINGRP, 17'h10000);
        2: write_reg(REG_MINGRP, 17'd0);
        3: ;
        default: write_reg(REG_MINGRP, 17'($urandom_range(1, 8)));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      total = eff_dim(9'(w)) * eff_dim(9'(h));
      dens = $urandom_range(10, 90);
      for (int i = 0; i < total; i++) begin
        it.operation = OP_LOAD;
        it.pixel_value = ($urandom_range(0, 99) < dens) ? FG_LEVEL :
                         8'($urandom_range(0, 254));
        send_item(it, 0, none);
        // Broken sequence: stray reads inside the load
        if (phase % 8 == 7 && $urandom_range(0, 9) == 0) begin
          it.operation = OP_READ;
          it.pixel_value = 8'($urandom());
          send_item(it, 0, none);
        end
      end
      // Hold the receiver off while reads keep coming
      if (phase == 1 || phase == 3) begin
        end_burst();
        hold_req = 1;
        wait (hold_cnt > 0);
        hold_req = 0;
      end
      n_reads = (total > 64) ? ((phase == 0) ? total + 3 : 24) :
                total * $urandom_range(1, 2) + $urandom_range(0, 3);
      for (int i = 0; i < n_reads; i++) begin
        it.operation = OP_READ;
        it.pixel_value = 8'($urandom());
        send_item(it, 0, none);
      end
      phase++;
    end

    // Drain
    end_burst();
    while (mask_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d transactions in %0d phases, %0d images filtered, %0d results",
             items_sent, phase, images_filtered, results_seen);
    $display("mismatches %0d, unexpected results %0d", mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && mask_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/sbrf_pkg.sv
src/small_blob_removal_filter.sv
src/sbrf_checker.sv
dv/testbench.sv
